// ===== sv/dsae_pkg.sv =====
// Shared types, selector table and constants for the delta selector array encoder.
package dsae_pkg;

	localparam int MaxWidth   = 32;
	localparam int StartWidth = MaxWidth / 2;
	localparam int NumSel     = 16;
	localparam int GroupSize  = 4;
	localparam int SelBits    = 4;

	// Width change and span for each selector code; code 0 is the one-gap full-width escape.
	localparam logic signed [2:0] SEL_DELTA [NumSel] = '{
		3'sd0,
		-3'sd3,
		-3'sd2, -3'sd2,
		-3'sd1, -3'sd1, -3'sd1,
		3'sd0, 3'sd0, 3'sd0,
		3'sd1, 3'sd1, 3'sd1,
		3'sd2, 3'sd2,
		3'sd3
	};

	localparam logic [2:0] SEL_SPAN [NumSel] = '{
		3'd1,
		3'd1,
		3'd1, 3'd2,
		3'd1, 3'd2, 3'd4,
		3'd1, 3'd2, 3'd4,
		3'd1, 3'd2, 3'd4,
		3'd1, 3'd2,
		3'd1
	};

	localparam logic [3:0] SEL_ESCAPE = 4'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_SCORE,
		ST_PICK,
		ST_SEL,
		ST_GAP,
		ST_ADV
	} dsae_state_t;

	typedef struct packed {
		logic accept;
		logic store;
		logic score;
		logic pick;
		logic emit_sel;
		logic emit_gap;
		logic advance;
	} dsae_cmd_t;

	typedef struct packed {
		logic [2:0] count;
		logic       final_item;
		logic       out_free;
		logic       width_zero;
		logic       last_gap;
		logic       more_groups;
	} dsae_stat_t;

endpackage

// ===== sv/dsae_in_if.sv =====
// Input channel carrying one array element per transaction.
interface dsae_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        is_final;

	modport source (output valid, output value, output is_final, input ready);
	modport sink (input valid, input value, input is_final, output ready);
endinterface

// ===== sv/dsae_out_if.sv =====
// Output channel carrying one stream field per transaction.
interface dsae_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] field_value;
	logic [5:0]  field_bits;
	logic        is_selector;
	logic        run_last;
	logic        array_end;

	modport source (output valid, output field_value, output field_bits, output is_selector,
		output run_last, output array_end, input ready);
	modport sink (input valid, input field_value, input field_bits, input is_selector,
		input run_last, input array_end, output ready);
endinterface

// ===== sv/dsae_ctrl.sv =====
// Controller state machine sequencing store, scoring, selection, emission and shift.
module dsae_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dsae_pkg::dsae_stat_t stat,
	output dsae_pkg::dsae_cmd_t  cmd
);

	dsae_pkg::dsae_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsae_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dsae_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = dsae_pkg::ST_STORE;
				end
			end
			dsae_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				// A group is encoded once four gaps are held, or always on the final element.
				if (stat.final_item || stat.count == 3'd3) begin
					state_d = dsae_pkg::ST_SCORE;
				end else begin
					state_d = dsae_pkg::ST_IDLE;
				end
			end
			dsae_pkg::ST_SCORE: begin
				cmd.score = 1'b1;
				state_d   = dsae_pkg::ST_PICK;
			end
			dsae_pkg::ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = dsae_pkg::ST_SEL;
			end
			dsae_pkg::ST_SEL: begin
				if (stat.out_free) begin
					cmd.emit_sel = 1'b1;
					state_d = stat.width_zero ? dsae_pkg::ST_ADV : dsae_pkg::ST_GAP;
				end
			end
			dsae_pkg::ST_GAP: begin
				if (stat.out_free) begin
					cmd.emit_gap = 1'b1;
					if (stat.last_gap) begin
						state_d = dsae_pkg::ST_ADV;
					end
				end
			end
			dsae_pkg::ST_ADV: begin
				cmd.advance = 1'b1;
				if (stat.final_item && stat.more_groups) begin
					state_d = dsae_pkg::ST_SCORE;
				end else begin
					state_d = dsae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsae_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/dsae_dp.sv =====
// Datapath: gap formation, pending group, selector scoring and output register.
module dsae_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          in_value,
	input  logic                 in_is_final,
	input  dsae_pkg::dsae_cmd_t  cmd,
	output dsae_pkg::dsae_stat_t stat,
	dsae_out_if.source           fields
);

	logic [31:0] prev_q;
	logic [5:0]  width_q;
	logic [31:0] gap_q;
	logic        final_q;
	logic [31:0] gaps_q [dsae_pkg::GroupSize];
	logic [5:0]  lens_q [dsae_pkg::GroupSize];
	logic [2:0]  count_q;
	logic signed [9:0] score_s1 [dsae_pkg::NumSel];
	logic              ok_s1    [dsae_pkg::NumSel];
	logic [3:0]  sel_q;
	logic [2:0]  span_q;
	logic [1:0]  idx_q;

	logic        out_valid_q;
	logic [31:0] out_value_q;
	logic [5:0]  out_bits_q;
	logic        out_sel_q;
	logic        out_last_q;
	logic        out_end_q;

	// Scoring terms
	logic signed [7:0] cand_w   [dsae_pkg::NumSel];
	logic              cand_ok  [dsae_pkg::NumSel];
	logic signed [9:0] cand_sc  [dsae_pkg::NumSel];
	logic        [8:0] len_sum  [dsae_pkg::NumSel];

	// Selection tree
	logic signed [9:0] t1_sc [8];
	logic        [3:0] t1_ix [8];
	logic              t1_ok [8];
	logic signed [9:0] t2_sc [4];
	logic        [3:0] t2_ix [4];
	logic              t2_ok [4];
	logic signed [9:0] t3_sc [2];
	logic        [3:0] t3_ix [2];
	logic              t3_ok [2];
	logic        [3:0] best_ix;

	logic [5:0]  store_len;
	logic [5:0]  width_next;
	logic [31:0] gap_mask;
	logic        more_groups;
	logic        tail_done;
	logic        out_free;

	function automatic logic [5:0] bit_length(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int b = 0; b < 32; b++) begin
			if (v[b]) begin
				n = 6'(b + 1);
			end
		end
		return n;
	endfunction

	assign store_len   = bit_length(gap_q);
	assign more_groups = (count_q != span_q);
	assign tail_done   = !(final_q && more_groups);
	assign out_free    = !out_valid_q || fields.ready;
	assign gap_mask    = (width_q >= 6'(dsae_pkg::MaxWidth)) ? 32'hFFFF_FFFF
		: ~(32'hFFFF_FFFF << width_q);

	assign stat.count       = count_q;
	assign stat.final_item  = final_q;
	assign stat.out_free    = out_free;
	assign stat.width_zero  = (width_q == 6'd0);
	assign stat.last_gap    = ({1'b0, idx_q} == span_q - 3'd1);
	assign stat.more_groups = more_groups;

	// Every selector is scored in parallel against the held lengths.
	always_comb begin
		for (int i = 0; i < dsae_pkg::NumSel; i++) begin
			cand_w[i]  = $signed({2'b00, width_q}) + 8'(dsae_pkg::SEL_DELTA[i]);
			cand_ok[i] = (cand_w[i] >= 8'sd0) && (cand_w[i] <= 8'(dsae_pkg::MaxWidth))
				&& (dsae_pkg::SEL_SPAN[i] <= count_q);
			len_sum[i] = 9'd0;
			for (int k = 0; k < dsae_pkg::GroupSize; k++) begin
				if (3'(k) < dsae_pkg::SEL_SPAN[i]) begin
					len_sum[i] = len_sum[i] + 9'(lens_q[k]);
					if ({2'b00, lens_q[k]} > cand_w[i]) begin
						cand_ok[i] = 1'b0;
					end
				end
			end
			cand_sc[i] = 10'($signed({2'b00, dsae_pkg::SEL_SPAN[i]}) - 10'sd1) * 10'sd4
				- (10'(cand_w[i]) * $signed({7'd0, dsae_pkg::SEL_SPAN[i]})
				- $signed({1'b0, len_sum[i]}));
		end
		// The escape selector always qualifies and scores on the first length only.
		cand_ok[0] = 1'b1;
		cand_sc[0] = $signed({4'd0, lens_q[0]}) - 10'(dsae_pkg::MaxWidth);
	end

	// Ties go to the lower code, so the tree matches a first-best scan.
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			if (ok_s1[2*j+1] && score_s1[2*j+1] > score_s1[2*j] || !ok_s1[2*j]) begin
				t1_sc[j] = score_s1[2*j+1];
				t1_ix[j] = 4'(2*j+1);
				t1_ok[j] = ok_s1[2*j+1];
			end else begin
				t1_sc[j] = score_s1[2*j];
				t1_ix[j] = 4'(2*j);
				t1_ok[j] = ok_s1[2*j];
			end
		end
		for (int j = 0; j < 4; j++) begin
			if (t1_ok[2*j+1] && (t1_sc[2*j+1] > t1_sc[2*j] || !t1_ok[2*j])) begin
				t2_sc[j] = t1_sc[2*j+1];
				t2_ix[j] = t1_ix[2*j+1];
				t2_ok[j] = 1'b1;
			end else begin
				t2_sc[j] = t1_sc[2*j];
				t2_ix[j] = t1_ix[2*j];
				t2_ok[j] = t1_ok[2*j];
			end
		end
		for (int j = 0; j < 2; j++) begin
			if (t2_ok[2*j+1] && (t2_sc[2*j+1] > t2_sc[2*j] || !t2_ok[2*j])) begin
				t3_sc[j] = t2_sc[2*j+1];
				t3_ix[j] = t2_ix[2*j+1];
				t3_ok[j] = 1'b1;
			end else begin
				t3_sc[j] = t2_sc[2*j];
				t3_ix[j] = t2_ix[2*j];
				t3_ok[j] = t2_ok[2*j];
			end
		end
		if (t3_ok[1] && (t3_sc[1] > t3_sc[0] || !t3_ok[0])) begin
			best_ix = t3_ix[1];
		end else begin
			best_ix = t3_ix[0];
		end
		if (best_ix == dsae_pkg::SEL_ESCAPE) begin
			width_next = 6'(dsae_pkg::MaxWidth);
		end else begin
			width_next = 6'($signed({2'b00, width_q}) + 8'(dsae_pkg::SEL_DELTA[best_ix]));
		end
	end

	// Control state with reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			width_q     <= 6'(dsae_pkg::StartWidth);
			count_q     <= '0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				prev_q  <= in_value;
				final_q <= in_is_final;
			end
			if (cmd.store) begin
				count_q <= count_q + 3'd1;
			end
			if (cmd.pick) begin
				width_q <= width_next;
			end
			if (cmd.advance) begin
				count_q <= count_q - span_q;
				if (final_q && !more_groups) begin
					prev_q  <= '0;
					width_q <= 6'(dsae_pkg::StartWidth);
				end
			end
			if (cmd.emit_sel || cmd.emit_gap) begin
				out_valid_q <= 1'b1;
			end else if (fields.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gap_q <= in_value - prev_q - 32'd1;
		end
		if (cmd.store) begin
			gaps_q[count_q[1:0]] <= gap_q;
			lens_q[count_q[1:0]] <= store_len;
		end
		if (cmd.score) begin
			for (int i = 0; i < dsae_pkg::NumSel; i++) begin
				score_s1[i] <= cand_sc[i];
				ok_s1[i]    <= cand_ok[i];
			end
		end
		if (cmd.pick) begin
			sel_q  <= best_ix;
			span_q <= dsae_pkg::SEL_SPAN[best_ix];
			idx_q  <= '0;
		end
		if (cmd.emit_sel) begin
			out_value_q <= {28'd0, sel_q};
			out_bits_q  <= 6'(dsae_pkg::SelBits);
			out_sel_q   <= 1'b1;
			out_last_q  <= (width_q == 6'd0) && tail_done;
			out_end_q   <= (width_q == 6'd0) && tail_done && final_q;
		end
		if (cmd.emit_gap) begin
			out_value_q <= gaps_q[idx_q] & gap_mask;
			out_bits_q  <= width_q;
			out_sel_q   <= 1'b0;
			out_last_q  <= stat.last_gap && tail_done;
			out_end_q   <= stat.last_gap && tail_done && final_q;
			idx_q       <= idx_q + 2'd1;
		end
		if (cmd.advance) begin
			for (int i = 0; i < dsae_pkg::GroupSize; i++) begin
				if (3'(i) + span_q < 3'(dsae_pkg::GroupSize)) begin
					gaps_q[i] <= gaps_q[2'(3'(i) + span_q)];
					lens_q[i] <= lens_q[2'(3'(i) + span_q)];
				end
			end
		end
	end

	assign fields.valid       = out_valid_q;
	assign fields.field_value = out_value_q;
	assign fields.field_bits  = out_bits_q;
	assign fields.is_selector = out_sel_q;
	assign fields.run_last    = out_last_q;
	assign fields.array_end   = out_end_q;

endmodule

// ===== sv/delta_selector_array_encoder.sv =====
// Top level of the delta selector array encoder: controller plus datapath.
//
// The items channel takes one array element per transaction: a 32-bit value and
// is_final, which marks the last element of the array. Each value becomes a gap
// (value minus previous value minus one) and is held with its bit length until
// four gaps are pending, or until the final element arrives. A group is then
// encoded: the best of the selector table is scored and chosen, its 4-bit code
// goes out on the fields channel, followed by the covered gaps at the new width.
// The last field caused by an element carries run_last, and on a final element
// array_end as well; after that the block starts a new array.
// An element that only fills the group passes through the idle and store states.
// An element that closes a group goes through store, score and pick, then one field
// per cycle from the output register while the receiver takes them, then a shift of
// the pending group; a final element repeats the group sequence until none is pending.
// The sequencing is set by the controller, which handles one element at a time.
// After reset the previous value is zero, the running width is 16 and nothing
// is pending. When the receiver stalls, the output register holds its field and
// the controller waits; no field is lost or repeated.
module delta_selector_array_encoder (
	input  logic        clk,
	input  logic        arst_n,
	dsae_in_if.sink     items,
	dsae_out_if.source  fields
);

	dsae_pkg::dsae_cmd_t  cmd;
	dsae_pkg::dsae_stat_t stat;

	// The controller owns the input handshake and issues one command per cycle, except while it waits for input or output.
	dsae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds all pending state and the output register.
	dsae_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_value    (items.value),
		.in_is_final (items.is_final),
		.cmd         (cmd),
		.stat        (stat),
		.fields      (fields)
	);

endmodule
